// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled while
// arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/scfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial command frame decoder package
// Payload types, action codes and sizing constants shared by the decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

	// Receive buffer depth in bytes and the width of the write index,
	// which must be able to hold the depth itself.
	localparam int BUF_DEPTH = 64;
	localparam int WIDX_W = $clog2(BUF_DEPTH + 1);

	// Only the header, the opcode and the two speed bytes are ever decoded.
	localparam int FRAME_BYTES = 7;
	localparam int SLOT_W = $clog2(FRAME_BYTES);

	localparam logic [7:0] HDR0 = 8'hC1;
	localparam logic [7:0] HDR1 = 8'hC2;
	localparam logic [7:0] HDR2 = 8'hC3;
	localparam logic [7:0] HDR3 = 8'hC4;

	localparam logic [7:0] OP_STOP = 8'h00;
	localparam logic [7:0] OP_START = 8'h01;
	localparam logic [7:0] OP_SET = 8'h02;

	localparam logic [7:0] IDLE_PARKED = 8'hFF;
	localparam logic [7:0] IDLE_TICKS_RESET = 8'd10;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [2:0] {
		ACT_STOP = 3'd0,
		ACT_START = 3'd1,
		ACT_SET = 3'd2,
		ACT_REJECT = 3'd3,
		ACT_UNKNOWN = 3'd4
	} action_t;

	typedef struct packed {
		logic kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		action_t action;
		logic [7:0] left_target_speed;
		logic [7:0] right_target_speed;
		logic motor_running;
	} out_item_t;

endpackage

// ===== src/serial_command_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Serial command frame decoder core
// Buffers serial bytes, closes a frame after an idle period counted in
// millisecond ticks and decodes stop, start and set-speed commands.
// ----------------------------------------------------------------------------
// Flow: a transfer in is registered in the input stage and processed from
// there; a result is loaded from the input stage into the output register,
// and a stall can hold it in the input stage on the way.
// Throughput: one transfer per cycle, set by the single input stage feeding
// one result register; input stalls only while a result waits to be taken.
// Reset: arst_n low clears the frame bytes, write index, targets and running
// flag, parks the idle counter at 255 and loads the threshold with 10.
`include "assert_macros.svh"

module serial_command_frame_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  scfd_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output scfd_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data
);
	import scfd_pkg::*;

	// Input stage. A transfer is captured here and acted on from this register.
	logic      valid_s1;
	in_item_t  item_s1;

	// Architectural state. Of the receive buffer only the first bytes are
	// ever read, so only those are kept in flops; the write index still
	// walks the full depth so that the buffer-full drop behaves the same.
	logic [7:0]        frame_q [FRAME_BYTES];
	logic [WIDX_W-1:0] wr_idx_q;
	logic [7:0]        idle_q;
	logic [7:0]        idle_ticks_q;
	logic [7:0]        left_q;
	logic [7:0]        right_q;
	logic              running_q;

	// Output register.
	logic       out_valid_q;
	out_item_t  out_data_q;

	// Next-state values.
	logic [WIDX_W-1:0] wr_idx_d;
	logic [7:0]        idle_d;
	logic [7:0]        left_d;
	logic [7:0]        right_d;
	logic              running_d;
	logic              store_en;
	action_t           action_d;
	logic              produce;
	logic              close_frame;
	logic              header_ok;
	logic              advance;

	// The stage may move on unless it holds a result and the output register
	// is still occupied by one that has not been taken.
	assign advance = !(valid_s1 && produce && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign close_frame = (item_s1.kind == KIND_TICK) && (idle_q == idle_ticks_q);
	assign header_ok = (frame_q[0] == HDR0) && (frame_q[1] == HDR1) &&
		(frame_q[2] == HDR2) && (frame_q[3] == HDR3);
	assign produce = close_frame && header_ok;

	always_comb begin
		wr_idx_d = wr_idx_q;
		idle_d = idle_q;
		left_d = left_q;
		right_d = right_q;
		running_d = running_q;
		store_en = 1'b0;
		action_d = ACT_UNKNOWN;
		if (item_s1.kind == KIND_BYTE) begin
			if (wr_idx_q < WIDX_W'(BUF_DEPTH)) begin
				// A byte restarts the idle period; bytes past the decoded
				// window are counted but not kept.
				idle_d = '0;
				store_en = (wr_idx_q < WIDX_W'(FRAME_BYTES));
				wr_idx_d = wr_idx_q + 1'b1;
			end else begin
				// Buffer full: the byte is dropped and writing wraps.
				wr_idx_d = '0;
			end
		end else if (close_frame) begin
			if (header_ok) begin
				unique case (frame_q[4])
					OP_STOP: begin
						left_d = '0;
						right_d = '0;
						running_d = 1'b0;
						action_d = ACT_STOP;
					end
					OP_START: begin
						if (frame_q[5] == 8'd0) begin
							action_d = ACT_REJECT;
						end else begin
							left_d = frame_q[5];
							right_d = frame_q[5];
							running_d = 1'b1;
							action_d = ACT_START;
						end
					end
					OP_SET: begin
						left_d = frame_q[5];
						right_d = frame_q[6];
						running_d = 1'b1;
						action_d = ACT_SET;
					end
					default: begin
						action_d = ACT_UNKNOWN;
					end
				endcase
			end
			wr_idx_d = '0;
			idle_d = IDLE_PARKED;
		end else if (idle_q < idle_ticks_q) begin
			idle_d = idle_q + 8'd1;
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= IDLE_TICKS_RESET;
		end else if (cfg_we) begin
			idle_ticks_q <= cfg_data;
		end
	end

	// Decoder state, updated when the staged transfer is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				frame_q[i] <= '0;
			end
			wr_idx_q <= '0;
			idle_q <= IDLE_PARKED;
			left_q <= '0;
			right_q <= '0;
			running_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (store_en) begin
				frame_q[wr_idx_q[SLOT_W-1:0]] <= item_s1.rx_byte;
			end
			wr_idx_q <= wr_idx_d;
			idle_q <= idle_d;
			left_q <= left_d;
			right_q <= right_d;
			running_q <= running_d;
		end
	end

	// Output register. It refills in the same cycle that its result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && produce && advance) begin
			out_data_q.action <= action_d;
			out_data_q.left_target_speed <= left_d;
			out_data_q.right_target_speed <= right_d;
			out_data_q.motor_running <= running_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A stop result always reports cleared targets and stopped motors.
	`ASSERT_IMPLIES(a_stop_clears, out_valid_q && out_data_q.action == ACT_STOP, !out_data_q.motor_running && out_data_q.left_target_speed == 8'd0 && out_data_q.right_target_speed == 8'd0, "stop result with nonzero targets")
	// The write index never runs past the buffer depth.
	`ASSERT_IMPLIES(a_widx_range, 1'b1, wr_idx_q <= WIDX_W'(BUF_DEPTH), "write index beyond buffer depth")
	// Closing a frame parks the idle counter and rewinds the write index.
	`ASSERT_NEXT(a_close_parks, valid_s1 && advance && close_frame, idle_q == IDLE_PARKED && wr_idx_q == '0, "frame close did not park counter")
	// Input is held back only by a pending result behind a blocked output.
	`ASSERT_IMPLIES(a_stall_cause, in_stall, valid_s1 && produce && out_valid_q && out_stall, "input stalled without a blocked result")

endmodule
